// ===== design/bccd_pkg.sv =====
// shared types and constants for the button click and chord detector
// no dependencies; imported by every module of the block

package bccd_pkg;

  localparam int unsigned NumButtons = 5;
  localparam int unsigned NumChords  = 3;

  localparam int unsigned HoldW = 8;
  localparam int unsigned MsW   = 16;
  localparam int unsigned TimeW = 32;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHORD_HOLD = 2'd0,
    CFG_DEBOUNCE   = 2'd1,
    CFG_LONG_PRESS = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_index_e;

  localparam logic [HoldW-1:0] HoldReset     = 8'd50;
  localparam logic [MsW-1:0]   DebounceReset = 16'd50;
  localparam logic [MsW-1:0]   LongReset     = 16'd1000;

  // timing limits shared by all click lanes
  typedef struct packed {
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] long_press_ms;
  } click_cfg_t;

  // what one click lane reports for a poll
  typedef struct packed {
    logic short_click;
    logic long_click;
  } click_res_t;

  // what one chord lane reports for a poll
  typedef struct packed {
    logic fire;
    logic blocked;
  } chord_res_t;

endpackage

// ===== design/bccd_chord.sv =====
// one chord detector lane: hold counter and block flag
// depends on bccd_pkg

module bccd_chord (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      en_i,
  input  logic                      held_i,
  input  logic [bccd_pkg::HoldW-1:0] hold_polls_i,
  output bccd_pkg::chord_res_t      res_o
);
  import bccd_pkg::*;

  logic [HoldW-1:0] count_q, count_d, count_inc;
  logic             blocked_q, blocked_d;
  logic             over;

  assign count_inc = count_q + HoldW'(1);
  assign over      = count_inc > hold_polls_i;

  always_comb begin
    count_d   = count_q;
    blocked_d = blocked_q;
    if (en_i) begin
      blocked_d = held_i;
      if (!held_i || over) begin
        count_d = '0;
      end else begin
        count_d = count_inc;
      end
    end
  end

  assign res_o.fire    = en_i & held_i & over;
  assign res_o.blocked = blocked_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      blocked_q <= 1'b0;
    end else if (step_i) begin
      count_q   <= count_d;
      blocked_q <= blocked_d;
    end
  end

endmodule

// ===== design/bccd_button.sv =====
// one click detector lane: press timestamp and release classification
// depends on bccd_pkg

module bccd_button (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       en_i,
  input  logic                       level_i,
  input  logic [bccd_pkg::TimeW-1:0] now_i,
  input  bccd_pkg::click_cfg_t       cfg_i,
  output bccd_pkg::click_res_t       res_o
);
  import bccd_pkg::*;

  logic             last_q;
  logic [TimeW-1:0] press_q;
  logic [TimeW-1:0] elapsed;
  logic             press, release_ev, valid_len;

  assign press      = en_i & ~level_i & last_q;
  assign release_ev = en_i & level_i & ~last_q;
  assign elapsed    = now_i - press_q;
  assign valid_len  = elapsed > TimeW'(cfg_i.debounce_ms);

  assign res_o.short_click = release_ev & valid_len & (elapsed <= TimeW'(cfg_i.long_press_ms));
  assign res_o.long_click  = release_ev & valid_len & (elapsed >  TimeW'(cfg_i.long_press_ms));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= 1'b1;
      press_q <= '0;
    end else if (step_i) begin
      if (press) begin
        last_q  <= 1'b0;
        press_q <= now_i;
      end else if (release_ev) begin
        last_q  <= 1'b1;
      end
    end
  end

endmodule

// ===== design/button_click_and_chord_detector_unit.sv =====
// top level of the button click and chord detector
// depends on bccd_pkg, bccd_chord and bccd_button

// One poll transaction carries five active-low button levels and the current
// millisecond time; each accepted poll yields exactly one result transaction in
// the next cycle, holding three chord request pulses and per-button short and
// long click masks. While s_axis_tready is high the block takes one poll per clock:
// three chord lanes (1+2+3, 1+2, 2+3) and five click lanes update in the accepting
// cycle, and a single output register holds the merged result, so s_axis_tready is
// high whenever that register is empty or being drained.
// Elapsed press time is taken modulo 2^32. A hold count of 255 never fires.
// Configuration writes are always accepted and should be issued while idle.

module button_click_and_chord_detector_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // poll input; tdata bits from low: sw1, sw2, sw3, enc, joy levels, now_ms[31:0], zero pad
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // result; tdata bits from low: chord_all_three, chord_one_two, chord_two_three,
  // short_clicks[4:0], long_clicks[4:0], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bccd_pkg::*;

  // configuration registers
  logic [HoldW-1:0] hold_q;
  logic [MsW-1:0]   debounce_q;
  logic [MsW-1:0]   long_q;
  click_cfg_t       click_cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q     <= HoldReset;
      debounce_q <= DebounceReset;
      long_q     <= LongReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_CHORD_HOLD: hold_q     <= cfg_data_i[HoldW-1:0];
        CFG_DEBOUNCE:   debounce_q <= cfg_data_i;
        CFG_LONG_PRESS: long_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign click_cfg.debounce_ms   = debounce_q;
  assign click_cfg.long_press_ms = long_q;

  // input unpacking
  logic [NumButtons-1:0] level;
  logic [TimeW-1:0]      now_ms;
  logic                  step;
  logic                  out_valid_q;

  assign level         = s_axis_tdata[NumButtons-1:0];
  assign now_ms        = s_axis_tdata[NumButtons +: TimeW];
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign step          = s_axis_tvalid & s_axis_tready;

  // chord lanes; the full chord gates the two pair chords
  logic             p1, p2, p3;
  chord_res_t       chord_res [NumChords];
  logic [NumChords-1:0] chord_held;
  logic [NumChords-1:0] chord_en;

  assign p1 = ~level[0];
  assign p2 = ~level[1];
  assign p3 = ~level[2];

  assign chord_held = {p2 & p3, p1 & p2, p1 & p2 & p3};
  assign chord_en   = {~chord_res[0].blocked, ~chord_res[0].blocked, 1'b1};

  for (genvar c = 0; c < NumChords; c++) begin : g_chord
    bccd_chord u_chord (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .step_i       (step),
      .en_i         (chord_en[c]),
      .held_i       (chord_held[c]),
      .hold_polls_i (hold_q),
      .res_o        (chord_res[c])
    );
  end

  // click lanes; a button that belongs to an active chord is not checked
  logic [NumButtons-1:0] click_en;
  click_res_t            click_res [NumButtons];
  logic [NumButtons-1:0] shorts, longs;
  logic                  b0, b1, b2;

  assign b0 = chord_res[0].blocked;
  assign b1 = chord_res[1].blocked;
  assign b2 = chord_res[2].blocked;

  assign click_en = {1'b1, 1'b1, ~b0 & ~b2, ~b0 & ~b1 & ~b2, ~b0 & ~b1};

  for (genvar b = 0; b < NumButtons; b++) begin : g_button
    bccd_button u_button (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step),
      .en_i    (click_en[b]),
      .level_i (level[b]),
      .now_i   (now_ms),
      .cfg_i   (click_cfg),
      .res_o   (click_res[b])
    );
    assign shorts[b] = click_res[b].short_click;
    assign longs[b]  = click_res[b].long_click;
  end

  // merge stage: one output register
  logic [15:0] out_data_q, out_data_d;

  assign out_data_d = {3'b000, longs, shorts,
                       chord_res[2].fire, chord_res[1].fire, chord_res[0].fire};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a button never reports both a short and a long click in one poll
  a_click_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_data_q[7:3] & out_data_q[12:8]) == 5'd0))
    else $error("short and long click on the same button");

  // the full chord firing means the pair chords were not evaluated
  a_full_blocks_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[0]) |-> (!out_data_q[1] && !out_data_q[2]))
    else $error("pair chord fired together with full chord");

  // a firing 1+2 chord suppresses clicks on buttons 1 and 2
  a_pair_suppress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[1]) |->
      (out_data_q[4:3] == 2'b00 && out_data_q[9:8] == 2'b00))
    else $error("click reported on a button of an active chord");

  // an accepted poll always produces a result on the next cycle
  a_poll_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("accepted poll produced no result");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[15:13] == 3'b000))
    else $error("result padding not zero");

endmodule
